### design/key_matrix_debounce_events_macros.svh
// ============================================================================
// Assertion macros for the key matrix debouncer
// Implication and next-cycle checks, compiled out when ASSERT_OFF is set.
// ============================================================================
`ifndef KEY_MATRIX_DEBOUNCE_EVENTS_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_EVENTS_MACROS_SVH

`ifndef ASSERT_OFF
`define KMD_ASSERT_IMP(label, clk_i, rst_ni, pre, post) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
        else $error("kmd check failed");
`define KMD_ASSERT_NEXT(label, clk_i, rst_ni, pre, post) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
        else $error("kmd check failed");
`else
`define KMD_ASSERT_IMP(label, clk_i, rst_ni, pre, post)
`define KMD_ASSERT_NEXT(label, clk_i, rst_ni, pre, post)
`endif

`endif

### design/kmd_pkg.sv
// ============================================================================
// kmd_pkg
// Types and constants shared by the key matrix debouncer.
// ============================================================================
package kmd_pkg;

    localparam int ROW_W        = 3;
    localparam int COL_W        = 4;
    localparam int COUNT_W      = 4;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_ADDR_LSB = 2;

    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PADDR_W-REG_ADDR_LSB-1:0] reg_idx_t;

    localparam reg_idx_t REG_DEBOUNCE_LIMIT = reg_idx_t'(0);
    localparam count_t   LIMIT_RESET        = count_t'(5);
    localparam count_t   LIMIT_MIN          = count_t'(1);

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } ev_kind_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    typedef struct packed {
        logic   stable;
        count_t count;
    } key_entry_t;

endpackage

### design/kmd_sample_if.sv
// ============================================================================
// kmd_sample_if
// Raw key sample channel: one matrix position and its sampled level.
// ============================================================================
interface kmd_sample_if;
    logic          valid;
    logic          ready;
    kmd_pkg::row_t key_row;
    kmd_pkg::col_t key_col;
    logic          raw_pressed;

    modport source (output valid, output key_row, output key_col, output raw_pressed,
                    input ready);
    modport sink   (input valid, input key_row, input key_col, input raw_pressed,
                    output ready);
endinterface

### design/kmd_event_if.sv
// ============================================================================
// kmd_event_if
// Key event channel: press, release or none, with key coordinates.
// ============================================================================
interface kmd_event_if;
    logic              valid;
    logic              ready;
    kmd_pkg::ev_kind_t event_kind;
    kmd_pkg::row_t     event_row;
    kmd_pkg::col_t     event_col;

    modport source (output valid, output event_kind, output event_row, output event_col,
                    input ready);
    modport sink   (input valid, input event_kind, input event_row, input event_col,
                    output ready);
endinterface

### design/kmd_ram.sv
// ============================================================================
// kmd_ram
// Simple dual-port RAM, one write port and one registered read port.
// ============================================================================
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/key_matrix_debounce_events.sv
// ============================================================================
// key_matrix_debounce_events
// Per-key saturating integrator debounce with one press, release or none word per sample.
// ============================================================================
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------
//  samples   | in  | valid/ready   | key_row, key_col, raw_pressed
//  events    | out | valid/ready   | event_kind, event_row, event_col
//  apb       | in  | psel/penable  | debounce_limit at byte address 0
//
//  One word per cycle sustained while events.ready holds; result valid from the result register after s1.
//  RAM read on the accept edge, update and result register on the edge that advances s1.
//  Key state RAM: one read and one write port, same-key hazard forwarded.
//  After reset a clearing pass over all ROWS*COLS keys holds samples.ready low.
//  A stalled events word holds the update stage; samples.ready follows it.
// ============================================================================
module key_matrix_debounce_events #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kmd_pkg::PADDR_W-1:0]  paddr,
    input  logic [kmd_pkg::PDATA_W-1:0]  pwdata,
    output logic [kmd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    kmd_sample_if.sink                   samples,
    kmd_event_if.source                  events
);

    import kmd_pkg::*;

`include "key_matrix_debounce_events_macros.svh"

    localparam int KEYS    = ROWS * COLS;
    localparam int IDX_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int ENTRY_W = $bits(key_entry_t);

    // configuration
    count_t   limit_reg;
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:REG_ADDR_LSB];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr && (cfg_idx == REG_DEBOUNCE_LIMIT))
        begin
            limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (cfg_idx == REG_DEBOUNCE_LIMIT) ? PDATA_W'(limit_reg) : '0;

    // clearing sequencer
    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;
    logic             clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        clearing     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing     = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(KEYS - 1))
                begin
                    state_next   = ST_RUN;
                    clr_idx_next = '0;
                end
            end
            ST_RUN:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // handshake
    logic out_valid_reg;
    logic s1_valid_reg;
    logic out_free;
    logic s1_adv;
    logic accept;

    assign out_free      = !out_valid_reg || events.ready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign samples.ready = !clearing && (!s1_valid_reg || out_free);
    assign accept        = samples.valid && samples.ready;

    // input stage
    logic             in_range;
    logic [IDX_W-1:0] in_idx;

    assign in_range = (int'(samples.key_row) < ROWS) && (int'(samples.key_col) < COLS);
    assign in_idx   = IDX_W'(int'(samples.key_row) * COLS + int'(samples.key_col));

    row_t             s1_row_reg;
    col_t             s1_col_reg;
    logic             s1_pressed_reg;
    logic             s1_in_range_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg      <= samples.key_row;
            s1_col_reg      <= samples.key_col;
            s1_pressed_reg  <= samples.raw_pressed;
            s1_in_range_reg <= in_range;
            s1_idx_reg      <= in_idx;
        end
    end

    // key state memory
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    key_entry_t         new_entry;
    logic               s1_we;

    assign s1_we     = s1_adv && s1_in_range_reg;
    assign ram_we    = clearing || s1_we;
    assign ram_waddr = clearing ? clr_idx_reg : s1_idx_reg;
    assign ram_wdata = clearing ? '0 : ENTRY_W'(new_entry);

    kmd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEYS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // bypass the write that lands on the read edge
    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_idx_reg  <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
    end

    // integrator update
    key_entry_t cur_entry;
    count_t     lim;
    count_t     cnt_new;
    logic       at_top;
    logic       at_zero;
    ev_kind_t   ev_kind;

    assign cur_entry = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
                       ? key_entry_t'(fwd_data_reg) : key_entry_t'(ram_rdata);
    assign lim       = (limit_reg == '0) ? LIMIT_MIN : limit_reg;

    always_comb
    begin
        if (s1_pressed_reg)
        begin
            cnt_new = (cur_entry.count < lim) ? cur_entry.count + 1'b1 : lim;
        end
        else
        begin
            cnt_new = (cur_entry.count != '0) ? cur_entry.count - 1'b1 : '0;
        end
    end

    assign at_top  = (cnt_new == lim);
    assign at_zero = (cnt_new == '0);

    always_comb
    begin
        new_entry.count  = cnt_new;
        new_entry.stable = cur_entry.stable;
        ev_kind          = EV_NONE;
        priority if (at_top && !cur_entry.stable)
        begin
            new_entry.stable = 1'b1;
            ev_kind          = EV_PRESS;
        end
        else if (at_zero && cur_entry.stable)
        begin
            new_entry.stable = 1'b0;
            ev_kind          = EV_RELEASE;
        end
        else
        begin
            ev_kind = EV_NONE;
        end
        if (!s1_in_range_reg)
        begin
            ev_kind = EV_NONE;
        end
    end

    // result register
    ev_kind_t out_kind_reg;
    row_t     out_row_reg;
    col_t     out_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (events.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_kind_reg <= ev_kind;
            out_row_reg  <= (ev_kind == EV_NONE) ? '0 : s1_row_reg;
            out_col_reg  <= (ev_kind == EV_NONE) ? '0 : s1_col_reg;
        end
    end

    assign events.valid      = out_valid_reg;
    assign events.event_kind = out_kind_reg;
    assign events.event_row  = out_row_reg;
    assign events.event_col  = out_col_reg;

    // checks
    `KMD_ASSERT_IMP(a_no_accept_while_clearing, clk, rst_n, state_reg == ST_CLEAR, !samples.ready)
    `KMD_ASSERT_IMP(a_no_event_zero_coords, clk, rst_n, out_valid_reg && (out_kind_reg == EV_NONE), (out_row_reg == '0) && (out_col_reg == '0))
    `KMD_ASSERT_IMP(a_run_write_from_update, clk, rst_n, ram_we && (state_reg == ST_RUN), s1_valid_reg && s1_in_range_reg && out_free)
    `KMD_ASSERT_NEXT(a_update_holds_on_stall, clk, rst_n, s1_valid_reg && !out_free, s1_valid_reg && $stable(s1_idx_reg))

endmodule

### dv/testbench.sv
// ============================================================================
// Key matrix debouncer testbench
// Drives raw key samples over the sample channel and checks every event word
// against a per-key integrator predictor. A directed table covers reset,
// limit extremes, a zero limit, an ignored register and a lowered limit.
// Random phases follow, each under its own debounce limit, with key runs,
// bounces and noise, and random stalls on both channels.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import kmd_pkg::*;

    localparam int ROWS            = 8;
    localparam int COLS            = 16;
    localparam int KEYS            = ROWS * COLS;
    localparam int NUM_DIRECTED    = 22;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int POOL_SIZE       = 4;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam reg_idx_t REG_SPARE = reg_idx_t'(1);

    typedef enum logic {
        STEP_SAMPLE = 1'b0,
        STEP_WRITE  = 1'b1
    } step_kind_t;

    typedef struct packed {
        ev_kind_t kind;
        row_t     row;
        col_t     col;
    } key_event_t;

    typedef struct packed {
        step_kind_t step;
        reg_idx_t   idx;
        count_t     value;
        row_t       row;
        col_t       col;
        logic       raw;
        logic       typed;
        ev_kind_t   kind;
        row_t       erow;
        col_t       ecol;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    kmd_sample_if sample_ch ();
    kmd_event_if  event_ch ();

    key_matrix_debounce_events #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (sample_ch),
        .events  (event_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state
    count_t     limit_reg = LIMIT_RESET;
    count_t     key_count [KEYS];
    logic       key_stable [KEYS];
    key_event_t pending_events [$];

    int  errors       = 0;
    int  samples_sent = 0;
    int  press_seen   = 0;
    int  release_seen = 0;
    int  limits_used  = 0;
    int  idle_cycles  = 0;
    int  stall_left   = 0;
    bit  calm         = 1'b0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  0, 0,  0, 1, EV_NONE,    0, 0},
        '{STEP_WRITE,  REG_DEBOUNCE_LIMIT, 1,  0, 0,  0, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  7, 15, 1, 1, EV_PRESS,   7, 15},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  7, 15, 1, 1, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  7, 15, 0, 1, EV_RELEASE, 7, 15},
        '{STEP_WRITE,  REG_DEBOUNCE_LIMIT, 0,  0, 0,  0, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  3, 9,  1, 1, EV_PRESS,   3, 9},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  3, 9,  0, 1, EV_RELEASE, 3, 9},
        '{STEP_WRITE,  REG_SPARE,          3,  0, 0,  0, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  2, 6,  1, 1, EV_PRESS,   2, 6},
        '{STEP_WRITE,  REG_DEBOUNCE_LIMIT, 15, 0, 0,  0, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  5, 4,  1, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  5, 4,  1, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  5, 4,  1, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  6, 10, 1, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  6, 10, 1, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  6, 10, 1, 0, EV_NONE,    0, 0},
        '{STEP_WRITE,  REG_DEBOUNCE_LIMIT, 2,  0, 0,  0, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  5, 4,  1, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  6, 10, 0, 0, EV_NONE,    0, 0},
        '{STEP_SAMPLE, REG_DEBOUNCE_LIMIT, 0,  2, 6,  0, 0, EV_NONE,    0, 0},
        '{STEP_WRITE,  REG_DEBOUNCE_LIMIT, 5,  0, 0,  0, 0, EV_NONE,    0, 0}
    };

    function automatic key_event_t debounce_sample(row_t row, col_t col, logic raw);
        key_event_t  ev;
        int unsigned key;
        count_t      lim;
        count_t      cnt;
        logic        level;
        ev  = '{kind: EV_NONE, row: '0, col: '0};
        lim = (limit_reg == '0) ? LIMIT_MIN : limit_reg;
        if (int'(row) >= ROWS || int'(col) >= COLS)
            return ev;
        key = int'(row) * COLS + int'(col);
        cnt = key_count[key];
        if (raw)
            cnt = (cnt < lim) ? count_t'(cnt + 1'b1) : lim;
        else if (cnt != '0)
            cnt = count_t'(cnt - 1'b1);
        key_count[key] = cnt;
        if (cnt == lim || cnt == '0)
        begin
            level = (cnt == lim);
            if (level != key_stable[key])
            begin
                key_stable[key] = level;
                ev.kind = level ? EV_PRESS : EV_RELEASE;
                ev.row  = row;
                ev.col  = col;
            end
        end
        return ev;
    endfunction

    // Receiver: random stall bursts, none once calm
    always @(posedge clk)
    begin
        if (calm)
            event_ch.ready <= 1'b1;
        else if (stall_left != 0)
        begin
            event_ch.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            event_ch.ready <= 1'b0;
            stall_left     <= $urandom_range(1, 13) - 1;
        end
        else
            event_ch.ready <= 1'b1;
    end

    // Event checker and watchdog
    always @(posedge clk)
    begin
        key_event_t exp_ev;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (event_ch.event_kind == EV_PRESS)
                press_seen++;
            if (event_ch.event_kind == EV_RELEASE)
                release_seen++;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event word: kind %0d row %0d col %0d",
                       event_ch.event_kind, event_ch.event_row, event_ch.event_col);
                errors++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (event_ch.event_kind !== exp_ev.kind)
                begin
                    $error("event_kind expected %0d actual %0d",
                           exp_ev.kind, event_ch.event_kind);
                    errors++;
                end
                if (event_ch.event_row !== exp_ev.row)
                begin
                    $error("event_row expected %0d actual %0d",
                           exp_ev.row, event_ch.event_row);
                    errors++;
                end
                if (event_ch.event_col !== exp_ev.col)
                begin
                    $error("event_col expected %0d actual %0d",
                           exp_ev.col, event_ch.event_col);
                    errors++;
                end
            end
        end
        if ((event_ch.valid && event_ch.ready) || (sample_ch.valid && sample_ch.ready)
            || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("key_matrix_debounce_events test failed");
            $finish;
        end
    end

    task automatic send_sample(row_t row, col_t col, logic raw, int gap);
        sample_ch.valid       <= 1'b1;
        sample_ch.key_row     <= row;
        sample_ch.key_col     <= col;
        sample_ch.raw_pressed <= raw;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_events();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
    endtask

    task automatic write_register(reg_idx_t idx, count_t value);
        logic [PDATA_W-1:0] data;
        drain_events();
        repeat (DRAIN_CYCLES) @(posedge clk);
        data    = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_ADDR_LSB;
        pwdata  <= {data[PDATA_W-1:COUNT_W], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_DEBOUNCE_LIMIT)
        begin
            limit_reg = value;
            limits_used++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int pick_gap();
        if (!calm && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 13);
        return 0;
    endfunction

    initial
    begin
        stim_row_t  srow;
        key_event_t ev;
        row_t       pool_row [POOL_SIZE];
        col_t       pool_col [POOL_SIZE];
        logic       pool_level [POOL_SIZE];
        row_t       r;
        col_t       c;
        logic       raw;
        count_t     lim_sel;
        int         k;
        int         lim_eff;

        for (int i = 0; i < KEYS; i++)
        begin
            key_count[i]  = '0;
            key_stable[i] = 1'b0;
        end
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.key_row     = '0;
        sample_ch.key_col     = '0;
        sample_ch.raw_pressed = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            srow = directed_rows[i];
            if (srow.step == STEP_WRITE)
                write_register(srow.idx, srow.value);
            else
            begin
                ev = debounce_sample(srow.row, srow.col, srow.raw);
                if (srow.typed)
                    ev = '{kind: srow.kind, row: srow.erow, col: srow.ecol};
                pending_events.push_back(ev);
                send_sample(srow.row, srow.col, srow.raw, pick_gap());
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            calm = (ph == NUM_PHASES - 1);
            case (ph)
                0:       lim_sel = count_t'(15);
                1:       lim_sel = LIMIT_MIN;
                2:       lim_sel = '0;
                default: lim_sel = count_t'($urandom_range(0, 15));
            endcase
            write_register(REG_DEBOUNCE_LIMIT, lim_sel);
            if ($urandom_range(0, 1) == 1)
                write_register(REG_SPARE, count_t'($urandom_range(0, 15)));
            lim_eff = (limit_reg == '0) ? 1 : int'(limit_reg);
            // refresh the key pool every other phase, keep counts across a limit change
            if (ph % 2 == 0)
            begin
                for (int p = 0; p < POOL_SIZE; p++)
                begin
                    pool_row[p]   = row_t'($urandom());
                    pool_col[p]   = col_t'($urandom());
                    pool_level[p] = 1'($urandom());
                end
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 3 && n == ITEMS_PER_PHASE / 2)
                    drain_events();
                if ($urandom_range(0, 9) == 0)
                begin
                    r   = row_t'($urandom());
                    c   = col_t'($urandom());
                    raw = 1'($urandom());
                end
                else
                begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    if ($urandom_range(0, 2 * lim_eff + 3) == 0)
                        pool_level[k] = ~pool_level[k];
                    r   = pool_row[k];
                    c   = pool_col[k];
                    raw = pool_level[k];
                    // bounce
                    if ($urandom_range(0, 7) == 0)
                        raw = ~raw;
                end
                pending_events.push_back(debounce_sample(r, c, raw));
                send_sample(r, c, raw, pick_gap());
            end
        end

        drain_events();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d key samples under %0d debounce limit settings",
                 samples_sent, limits_used);
        $display("Saw %0d press and %0d release words, %0d mismatches",
                 press_seen, release_seen, errors);
        if (errors == 0)
            $display("key_matrix_debounce_events test passed");
        else
            $display("key_matrix_debounce_events test failed");
        $finish;
    end

endmodule
